@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and types for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;
  localparam int HeapBytes   = 4096;
  localparam int MaxBlocks   = 256;
  localparam int HeaderBytes = 16;
  localparam int MaxAlign    = 16;
  localparam int MinPayload  = 1;
  localparam int MinTotal    = HeaderBytes + 1;

  localparam int AW = $clog2(MaxBlocks);    // table index width
  localparam int CW = AW + 1;               // block count width
  localparam int SW = 13;                   // byte quantity width

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_NULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] size;
    logic          used;
  } entry_t;
endpackage

@@ rtl/first_fit_heap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator with coalescing over an address-ordered block table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: raise start with the in_ fields while busy is low; the
//   request is taken on that edge and busy rises until the result is out.
//   Result channel: out_valid is high for one cycle with out_status and
//   out_payload_offset; the receiver must take it then, it cannot stall.
//   Config channel: cfg_valid/cfg_ready write heap_size; cfg_ready is high
//   only while no request is in flight. A write resets the heap to a single
//   free block.
// Timing:
//   The block table sits in one single-port-read, single-write memory with a
//   registered read. A request first scans entries in order (one read issue
//   per cycle), then shifts the table tail after the hit up by one (split)
//   or down by one or two (merge), one entry per cycle. The scan stops at
//   the hit and the shift covers only the entries after it; refused and
//   null requests skip the scan and go straight to the result. busy drops
//   in the result cycle, so the next transfer may land there.
// Reset:
//   rst_n clears control; the heap is 4096 bytes with entry 0 a free whole
//   heap block. No clearing pass is needed: the live entry count bounds all
//   reads. A config write rewrites entry 0 while busy is held high.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_req_type,
  input  logic [12:0]   in_req_size,
  input  logic [7:0]    in_req_alignment,
  input  logic [11:0]   in_free_offset,
  input  logic          in_free_is_null,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic [11:0]   out_payload_offset,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [12:0]   cfg_heap_size
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_NEXT, S_PREV, S_SHUP, S_SHDN, S_WRITE, S_DONE
  } state_t;

  // table memory
  entry_t mem [MaxBlocks];
  entry_t rd_q;
  logic   we;
  logic [AW-1:0] wa, ra;
  entry_t wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic          type_r;
  logic [SW-1:0] need_r;
  logic [11:0]   off_r;
  logic [CW-1:0] idx_r;       // scan pointer / shift pointer
  logic          rdv_r;       // rd_q holds entry idx_r-1 of a scan
  logic [CW-1:0] hit_r;       // matched index
  entry_t        hit_e_r, prev_e_r;
  logic          has_prev_r, prev_free_r;
  logic [1:0]    gap_r;       // entries removed by merge
  logic [CW-1:0] lo_r;        // first index to overwrite
  entry_t        new_r;       // entry to write at lo_r (merged, split remainder or allocated)
  logic          split_r;
  logic [2:0]    st_r;
  logic [11:0]   po_r;
  logic          ov_r;
  logic          init_r;      // entry 0 must be (re)written
  logic [SW-1:0] init_sz_r;

  assign busy      = (state_r != S_IDLE) || init_r;
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_payload_offset = po_r;

  // allocate request check
  logic bad_req;
  always_comb begin
    bad_req = (in_req_size == '0) || (in_req_alignment == '0) ||
              ((in_req_alignment & (in_req_alignment - 8'd1)) != '0) ||
              (in_req_alignment > 8'(MaxAlign));
  end

  // scan match on rd_q (entry idx_r-1)
  logic match;
  always_comb begin
    if (!type_r) match = !rd_q.used && (rd_q.size >= need_r);
    else match = rd_q.used && (rd_q.start + SW'(HeaderBytes) == {1'b0, off_r});
  end

  logic [SW-1:0] cfg_sz;
  always_comb begin
    cfg_sz = cfg_heap_size;
    if (cfg_sz < SW'(MinTotal)) cfg_sz = SW'(MinTotal);
    if (cfg_sz > SW'(HeapBytes)) cfg_sz = SW'(HeapBytes);
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (init_r) begin
          we = 1'b1;
          wd = '{start: '0, size: init_sz_r - SW'(HeaderBytes), used: 1'b0};
        end
      end
      S_SHUP: begin
        // read idx_r-1 earlier, write to idx_r
        ra = rdv_r ? idx_r[AW-1:0] - AW'(2) : idx_r[AW-1:0] - AW'(1);
        if (rdv_r) begin
          we = 1'b1;
          wa = idx_r[AW-1:0];
          wd = rd_q;
        end
      end
      S_SHDN: begin
        ra = idx_r[AW-1:0] + AW'(gap_r) + (rdv_r ? AW'(1) : AW'(0));
        if (rdv_r) begin
          we = 1'b1;
          wa = idx_r[AW-1:0];
          wd = rd_q;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        wa = lo_r[AW-1:0];
        wd = new_r;
      end
      default: ;
    endcase
  end

  entry_t rest_e;
  logic [SW-1:0] sum1;
  always_comb begin
    rest_e.start = rd_q.start + SW'(HeaderBytes) + need_r;
    rest_e.size  = rd_q.size - need_r - SW'(HeaderBytes);
    rest_e.used  = 1'b0;
    sum1 = hit_e_r.size + SW'(HeaderBytes) + rd_q.size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= CW'(1);
      init_r    <= 1'b1;
      init_sz_r <= SW'(HeapBytes);
      ov_r      <= 1'b0;
      rdv_r     <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          init_r <= 1'b0;
          if (cfg_valid && cfg_ready) begin
            init_sz_r <= cfg_sz;
            init_r    <= 1'b1;
            count_r   <= CW'(1);
          end else if (start && !init_r) begin
            type_r <= in_req_type;
            need_r <= in_req_size;
            off_r  <= in_free_offset;
            po_r   <= '0;
            idx_r  <= '0;
            rdv_r  <= 1'b0;
            has_prev_r  <= 1'b0;
            prev_free_r <= 1'b0;
            if (!in_req_type && bad_req) begin
              st_r <= ST_INVALID; state_r <= S_DONE;
            end else if (in_req_type && in_free_is_null) begin
              st_r <= ST_NULL; state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue idx_r, check rd_q for idx_r-1
          if (rdv_r && match) begin
            hit_r   <= idx_r - CW'(1);
            hit_e_r <= rd_q;
            rdv_r   <= 1'b0;
            if (!type_r) begin
              // split needs the current entry; decide now
              if (rd_q.size >= need_r + SW'(MinTotal) && count_r < CW'(MaxBlocks)) begin
                split_r <= 1'b1;
                new_r   <= rest_e;
                lo_r    <= idx_r;          // new free entry at hit+1
                idx_r   <= count_r;
                count_r <= count_r + CW'(1);
                gap_r   <= '0;
                state_r <= S_SHUP;
              end else begin
                split_r <= 1'b0;
                new_r   <= '{start: rd_q.start, size: rd_q.size, used: 1'b1};
                lo_r    <= idx_r - CW'(1);
                gap_r   <= '0;
                state_r <= S_WRITE;
              end
              st_r <= ST_OK;
              po_r <= 12'(rd_q.start + SW'(HeaderBytes));
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_NEXT;
            end
          end else if (idx_r >= count_r + CW'(1)) begin
            st_r    <= type_r ? ST_UNKNOWN : ST_NOFIT;
            state_r <= S_DONE;
          end else begin
            if (rdv_r) begin
              has_prev_r  <= 1'b1;
              prev_free_r <= !rd_q.used;
              prev_e_r    <= rd_q;
            end
            rdv_r <= (idx_r < count_r);
            idx_r <= idx_r + CW'(1);
            if (idx_r == count_r) begin
              st_r    <= type_r ? ST_UNKNOWN : ST_NOFIT;
              state_r <= S_DONE;
            end
          end
        end
        S_NEXT: begin
          // rd_q now holds entry hit+1 when it exists
          gap_r <= '0;
          new_r <= '{start: hit_e_r.start, size: hit_e_r.size, used: 1'b0};
          lo_r  <= hit_r;
          if (hit_r + CW'(1) < count_r && !rd_q.used) begin
            gap_r <= 2'd1;
            new_r <= '{start: hit_e_r.start, size: sum1, used: 1'b0};
          end
          state_r <= S_PREV;
          st_r    <= ST_OK;
        end
        S_PREV: begin
          if (has_prev_r && prev_free_r) begin
            lo_r  <= hit_r - CW'(1);
            gap_r <= gap_r + 2'd1;
            new_r <= '{start: prev_e_r.start,
                       size: prev_e_r.size + SW'(HeaderBytes) + new_r.size,
                       used: 1'b0};
          end
          state_r <= S_WRITE;
          split_r <= 1'b0;
        end
        S_SHUP: begin
          // move entries count-2 .. hit+1 up by one
          if (idx_r > lo_r) begin
            if (rdv_r) idx_r <= idx_r - CW'(1);
            rdv_r <= 1'b1;
            if (rdv_r && idx_r == lo_r + CW'(1)) begin
              rdv_r <= 1'b0;
              state_r <= S_WRITE;
            end
          end else begin
            rdv_r   <= 1'b0;
            state_r <= S_WRITE;
          end
        end
        S_SHDN: begin
          // move entries lo+1+gap .. count-1 down by gap
          if (rdv_r) idx_r <= idx_r + CW'(1);
          rdv_r <= 1'b1;
          if ((rdv_r ? idx_r + CW'(1) : idx_r) + CW'(gap_r) >= count_r) begin
            count_r <= count_r - CW'(gap_r);
            rdv_r   <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_WRITE: begin
          if (split_r) begin
            // new free entry written at lo; mark hit entry used and sized
            split_r <= 1'b0;
            lo_r    <= hit_r;
            new_r   <= '{start: hit_e_r.start, size: need_r, used: 1'b1};
          end else if (gap_r != '0) begin
            idx_r   <= lo_r + CW'(1);
            rdv_r   <= 1'b0;
            state_r <= S_SHDN;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          ov_r    <= 1'b1;
          if (st_r != ST_OK) po_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
